// ===== sv/lpc_pkg.sv =====
// Shared types and constants for the line position centroid block.
package lpc_pkg;

  localparam int MAX_SENSORS = 16;
  localparam int IDX_W       = $clog2(MAX_SENSORS);
  localparam int READING_W   = 10;
  localparam int THRESH_W    = 10;
  localparam int COUNT_W     = 5;
  localparam int SUM_W       = 7;
  localparam int DARK_W      = 5;
  localparam int FRAC_W      = 8;
  localparam int POS_W       = 12;
  localparam int DIVIDEND_W  = SUM_W + FRAC_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 16;
  localparam int STEP_W      = $clog2(DIVIDEND_W);

  localparam logic [THRESH_W-1:0]  THRESH_RESET = THRESH_W'(500);
  localparam logic [COUNT_W-1:0]   COUNT_RESET  = COUNT_W'(8);
  localparam logic [STEP_W-1:0]    LAST_STEP    = STEP_W'(DIVIDEND_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT   = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_OUTPUT = 3'b100
  } state_t;

  typedef struct packed {
    logic accept;  // sample transfer in the middle of a row
    logic load;    // last sample of the row: start the divider
    logic step;    // one divider iteration
  } lpc_cmd_t;

  typedef struct packed {
    logic is_last;
    logic div_done;
  } lpc_status_t;

endpackage

// ===== sv/lpc_ctrl.sv =====
// Controller state machine: row sampling, division sequencing and result handoff.
module lpc_ctrl import lpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  lpc_status_t status,
  output lpc_cmd_t    cmd
);

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (status.is_last) begin
            cmd.load   = 1'b1;
            state_next = ST_DIVIDE;
          end else begin
            cmd.accept = 1'b1;
          end
        end
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (status.div_done) state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUTPUT);

endmodule

// ===== sv/lpc_datapath.sv =====
// Datapath: configuration registers, row accumulators and a bit-serial restoring divider.
module lpc_datapath import lpc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [READING_W-1:0]   reading,
  input  lpc_cmd_t               cmd,
  output lpc_status_t            status,
  output logic [POS_W-1:0]       position_q8,
  output logic                   none_found
);

  logic [THRESH_W-1:0]   dark_threshold;
  logic [COUNT_W-1:0]    sensor_count;
  logic [IDX_W-1:0]      sensor_index;
  logic [DARK_W-1:0]     dark_count;
  logic [SUM_W-1:0]      index_sum;

  logic [DIVIDEND_W-1:0] dq;       // dividend in, quotient out
  logic [DARK_W-1:0]     rem;
  logic [DARK_W-1:0]     divisor;
  logic [STEP_W-1:0]     step_cnt;
  logic                  none_reg;

  logic [IDX_W-1:0]      last_index;
  logic                  dark;
  logic [SUM_W-1:0]      sum_upd;
  logic [DARK_W-1:0]     count_upd;
  logic [DARK_W:0]       trial;
  logic                  fits;
  logic [DARK_W:0]       trial_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_threshold <= THRESH_RESET;
      sensor_count   <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DARK_THRESHOLD: dark_threshold <= cfg_data[THRESH_W-1:0];
        REG_SENSOR_COUNT:   sensor_count   <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the row length to 1..MAX_SENSORS and take its last index.
  always_comb begin
    priority if (sensor_count == '0)
      last_index = '0;
    else if (sensor_count > COUNT_W'(MAX_SENSORS))
      last_index = IDX_W'(MAX_SENSORS - 1);
    else
      last_index = IDX_W'(sensor_count - COUNT_W'(1));
  end

  assign dark      = (reading <= dark_threshold);
  assign sum_upd   = dark ? index_sum + SUM_W'(sensor_index) : index_sum;
  assign count_upd = dark ? dark_count + DARK_W'(1) : dark_count;

  assign trial      = {rem, dq[DIVIDEND_W-1]};
  assign fits       = (trial >= {1'b0, divisor});
  assign trial_diff = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_index <= '0;
      dark_count   <= '0;
      index_sum    <= '0;
    end else if (cmd.load) begin
      sensor_index <= '0;
      dark_count   <= '0;
      index_sum    <= '0;
    end else if (cmd.accept) begin
      sensor_index <= sensor_index + IDX_W'(1);
      dark_count   <= count_upd;
      index_sum    <= sum_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.load) begin
      step_cnt <= '0;
    end else if (cmd.step) begin
      step_cnt <= step_cnt + STEP_W'(1);
    end
  end

  // Divider payload: one quotient bit per step, most significant first.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dq       <= {sum_upd, FRAC_W'(0)};
      rem      <= '0;
      divisor  <= count_upd;
      none_reg <= (count_upd == '0);
    end else if (cmd.step) begin
      dq  <= {dq[DIVIDEND_W-2:0], fits};
      rem <= fits ? trial_diff[DARK_W-1:0] : trial[DARK_W-1:0];
    end
  end

  assign status.is_last  = (sensor_index >= last_index);
  assign status.div_done = (step_cnt == LAST_STEP);

  assign position_q8 = none_reg ? '0 : dq[POS_W-1:0];
  assign none_found  = none_reg;

endmodule

// ===== sv/line_position_centroid.sv =====
// Top level of the line position centroid block.
//
//  port group   dir  payload                                   transfer
//  s_*          in   tdata[9:0] reading                        s_tvalid & s_tready
//  m_*          out  tdata[11:0] position_q8, tuser none_found m_tvalid & m_tready
//  cfg_*        in   cfg_index selects register, cfg_data      cfg_we
//
// A sample in the middle of a row is accumulated while the block stays idle. The last
// sample of a row starts a restoring divider that produces one quotient bit per cycle;
// the row-ending sample is followed by the divider run and then by the result, which
// waits for m_tready.
// No sample is taken while the divider runs or a result is pending.
// Reset (rst, synchronous) clears the row accumulators and restores the register defaults.
module line_position_centroid import lpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] reading, rest zero
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [11:0] position_q8, rest zero
  output logic                  m_tuser    // [0] none_found
);

  lpc_cmd_t         cmd;
  lpc_status_t      status;
  logic [POS_W-1:0] position_q8;
  logic             none_found;

  lpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lpc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .reading     (s_tdata[READING_W-1:0]),
    .cmd         (cmd),
    .status      (status),
    .position_q8 (position_q8),
    .none_found  (none_found)
  );

  assign m_tdata = {(M_TDATA_W - POS_W)'(0), position_q8};
  assign m_tuser = none_found;

  // Never take a sample while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready))
    else $error("sample taken while result pending");

  // A none-found result carries a zero position.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("none_found with nonzero position");

  // After a result transfer the block is ready for the next row.
  a_ready_after: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
    else $error("not ready after result transfer");

  // The row-ending sample is followed by the divider run, not by a result.
  a_load_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (!s_tready && !m_tvalid))
    else $error("divider did not start after last sample");

endmodule
